[hdl/fpw_pkg.sv]
// Shared types, constants and helper functions for the framebuffer pixel writer.
// No dependencies.
package fpw_pkg;

    typedef enum logic [1:0] {
        MODE_PLOT       = 2'd0,
        MODE_FILL_START = 2'd1,
        MODE_FILL_TICK  = 2'd2
    } t_mode;

    localparam logic [2:0] CFG_FRAME_BASE     = 3'd0;
    localparam logic [2:0] CFG_BITS_PER_PIXEL = 3'd1;
    localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_SCREEN_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_LINE_PITCH     = 3'd4;

    localparam logic [31:0] RST_FRAME_BASE     = 32'd0;
    localparam logic [5:0]  RST_BITS_PER_PIXEL = 6'd32;
    localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd640;
    localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd480;
    localparam logic [14:0] RST_LINE_PITCH     = 15'd2560;

    localparam logic [5:0] DEPTH_32 = 6'd32;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_16 = 6'd16;

    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_2    = 3'd2;
    localparam logic [2:0] BYTES_3    = 3'd3;
    localparam logic [2:0] BYTES_4    = 3'd4;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [5:0]  bits_per_pixel;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [14:0] line_pitch;
    } t_cfg;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [2:0] depth_bytes(input logic [5:0] bpp);
        logic [2:0] n;
        unique case (bpp)
            DEPTH_32: n = BYTES_4;
            DEPTH_24: n = BYTES_3;
            DEPTH_16: n = BYTES_2;
            default:  n = BYTES_NONE;
        endcase
        return n;
    endfunction

endpackage

[hdl/fpw_pixel_calc.sv]
// Pixel address and color packing for one write.
// Depends on fpw_pkg.
module fpw_pixel_calc #(
    parameter int ADDRESS_BITS = 32,
    parameter int POS_W        = 15
) (
    input  fpw_pkg::t_cfg     i_cfg,
    input  logic [POS_W-1:0]  i_col,
    input  logic [POS_W-1:0]  i_line,
    input  logic [31:0]       i_color,
    output logic [31:0]       o_address,
    output logic [31:0]       o_data,
    output logic [2:0]        o_byte_count
);

    localparam int OW   = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int PW   = POS_W + 15;
    localparam int CBW  = POS_W + 2;
    localparam int SW   = ((POS_W + 17) > 32) ? (POS_W + 17) : 32;

    logic [2:0]     bpb;
    logic [PW-1:0]  line_offset;
    logic [CBW-1:0] col_offset;
    logic [SW-1:0]  sum;

    always_comb begin
        bpb         = fpw_pkg::depth_bytes(i_cfg.bits_per_pixel);
        line_offset = PW'(i_line) * PW'(i_cfg.line_pitch);
        unique case (bpb)
            fpw_pkg::BYTES_4: col_offset = {i_col, 2'b00};
            fpw_pkg::BYTES_3: col_offset = CBW'({i_col, 1'b0}) + CBW'(i_col);
            default:          col_offset = CBW'({i_col, 1'b0});
        endcase
        sum       = SW'(i_cfg.frame_base) + SW'(line_offset) + SW'(col_offset);
        o_address = 32'(sum[OW-1:0]);
        unique case (bpb)
            fpw_pkg::BYTES_4: o_data = i_color;
            fpw_pkg::BYTES_3: o_data = {8'h00, i_color[23:0]};
            default: o_data = {16'h0000,
                               fpw_pkg::pack565(i_color[23:16], i_color[15:8], i_color[7:0])};
        endcase
        o_byte_count = bpb;
    end

endmodule

[hdl/framebuffer_pixel_writer.sv]
// Framebuffer pixel writer top level: config registers, fill sequencer, pipeline.
// Depends on fpw_pkg and fpw_pixel_calc.
//
// Takes one item per clock unless o_in_stall is high and presents its write, if
// any, from the result register: items land in an input register, logic forms
// the address and packed pixel, and a result register drives the write port.
// The input register also absorbs one item while a result is stalled, so a
// stall on the write side reaches the input only when both stages are full.
// The longest path is the line * pitch product followed by the address add.
// Fill start items and fill ticks at unsupported depths produce no write.
module framebuffer_pixel_writer #(
    parameter int MAX_DIMENSION = 4096,
    parameter int ADDRESS_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [31:0] i_fill_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic [2:0]  o_byte_count,
    output logic        o_fill_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int DIM_W = ($clog2(MAX_DIMENSION + 1) > 13) ? $clog2(MAX_DIMENSION + 1) : 13;
    localparam int POS_W = (CNT_W > 15) ? CNT_W : 15;
    localparam int CW    = ((DIM_W > POS_W) ? DIM_W : POS_W) + 1;

    fpw_pkg::t_cfg r_cfg;

    logic               r_in_valid;
    fpw_pkg::t_mode     r_in_mode;
    logic [15:0]        r_in_x;
    logic [15:0]        r_in_y;
    logic [7:0]         r_in_red;
    logic [7:0]         r_in_green;
    logic [7:0]         r_in_blue;
    logic [31:0]        r_in_fill_color;

    logic               r_fill_active;
    logic [CNT_W-1:0]   r_fill_col;
    logic [CNT_W-1:0]   r_fill_line;
    logic [31:0]        r_held_color;
    logic               n_fill_active;
    logic [CNT_W-1:0]   n_fill_col;
    logic [CNT_W-1:0]   n_fill_line;
    logic [31:0]        n_held_color;

    logic               r_out_valid;
    logic [31:0]        r_out_address;
    logic [31:0]        r_out_data;
    logic [2:0]         r_out_byte_count;
    logic               r_out_fill_done;
    logic               n_out_valid;
    logic               n_out_fill_done;

    logic               advance;
    logic [DIM_W-1:0]   w_clamp;
    logic [DIM_W-1:0]   h_clamp;
    logic               depth_ok;
    logic               plot_ok;
    logic               fill_in_range;
    logic               col_last;
    logic               fill_last;
    logic [POS_W-1:0]   calc_col;
    logic [POS_W-1:0]   calc_line;
    logic [31:0]        calc_color;
    logic [31:0]        calc_address;
    logic [31:0]        calc_data;
    logic [2:0]         calc_byte_count;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base     <= fpw_pkg::RST_FRAME_BASE;
            r_cfg.bits_per_pixel <= fpw_pkg::RST_BITS_PER_PIXEL;
            r_cfg.screen_width   <= fpw_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height  <= fpw_pkg::RST_SCREEN_HEIGHT;
            r_cfg.line_pitch     <= fpw_pkg::RST_LINE_PITCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpw_pkg::CFG_FRAME_BASE:     r_cfg.frame_base     <= i_cfg_data;
                fpw_pkg::CFG_BITS_PER_PIXEL: r_cfg.bits_per_pixel <= i_cfg_data[5:0];
                fpw_pkg::CFG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_data[12:0];
                fpw_pkg::CFG_SCREEN_HEIGHT:  r_cfg.screen_height  <= i_cfg_data[12:0];
                fpw_pkg::CFG_LINE_PITCH:     r_cfg.line_pitch     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_mode       <= fpw_pkg::t_mode'(i_mode);
            r_in_x          <= i_pos_x;
            r_in_y          <= i_pos_y;
            r_in_red        <= i_red;
            r_in_green      <= i_green;
            r_in_blue       <= i_blue;
            r_in_fill_color <= i_fill_color;
        end
    end

    always_comb begin
        w_clamp = (DIM_W'(r_cfg.screen_width) > DIM_W'(MAX_DIMENSION))
                ? DIM_W'(MAX_DIMENSION) : DIM_W'(r_cfg.screen_width);
        h_clamp = (DIM_W'(r_cfg.screen_height) > DIM_W'(MAX_DIMENSION))
                ? DIM_W'(MAX_DIMENSION) : DIM_W'(r_cfg.screen_height);
        depth_ok = fpw_pkg::depth_bytes(r_cfg.bits_per_pixel) != fpw_pkg::BYTES_NONE;
        plot_ok  = !r_in_x[15] && !r_in_y[15]
                && (CW'(r_in_x[14:0]) < CW'(w_clamp))
                && (CW'(r_in_y[14:0]) < CW'(h_clamp));
        fill_in_range = (CW'(r_fill_col) < CW'(w_clamp)) && (CW'(r_fill_line) < CW'(h_clamp));
        col_last  = (CW'(r_fill_col) + CW'(1)) >= CW'(w_clamp);
        fill_last = col_last && ((CW'(r_fill_line) + CW'(1)) >= CW'(h_clamp));
    end

    always_comb begin
        if (r_in_mode == fpw_pkg::MODE_PLOT) begin
            calc_col   = POS_W'(r_in_x[14:0]);
            calc_line  = POS_W'(r_in_y[14:0]);
            calc_color = {8'h00, r_in_red, r_in_green, r_in_blue};
        end else begin
            calc_col   = POS_W'(r_fill_col);
            calc_line  = POS_W'(r_fill_line);
            calc_color = r_held_color;
        end
    end

    fpw_pixel_calc #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .POS_W        (POS_W)
    ) u_calc (
        .i_cfg        (r_cfg),
        .i_col        (calc_col),
        .i_line       (calc_line),
        .i_color      (calc_color),
        .o_address    (calc_address),
        .o_data       (calc_data),
        .o_byte_count (calc_byte_count)
    );

    always_comb begin
        n_fill_active   = r_fill_active;
        n_fill_col      = r_fill_col;
        n_fill_line     = r_fill_line;
        n_held_color    = r_held_color;
        n_out_valid     = 1'b0;
        n_out_fill_done = 1'b0;
        unique case (r_in_mode)
            fpw_pkg::MODE_PLOT: begin
                n_out_valid = plot_ok && depth_ok;
            end
            fpw_pkg::MODE_FILL_START: begin
                if (r_cfg.frame_base != 32'd0 && w_clamp != '0 && h_clamp != '0) begin
                    n_fill_active = 1'b1;
                    n_fill_col    = '0;
                    n_fill_line   = '0;
                    n_held_color  = r_in_fill_color;
                end
            end
            fpw_pkg::MODE_FILL_TICK: begin
                if (r_fill_active) begin
                    if (!fill_in_range || fill_last) begin
                        n_fill_active = 1'b0;
                        n_fill_col    = '0;
                        n_fill_line   = '0;
                    end else if (col_last) begin
                        n_fill_col  = '0;
                        n_fill_line = r_fill_line + CNT_W'(1);
                    end else begin
                        n_fill_col = r_fill_col + CNT_W'(1);
                    end
                    n_out_valid     = fill_in_range && depth_ok;
                    n_out_fill_done = fill_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_active <= 1'b0;
            r_fill_col    <= '0;
            r_fill_line   <= '0;
            r_held_color  <= '0;
            r_out_valid   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_out_valid;
            if (r_in_valid) begin
                r_fill_active <= n_fill_active;
                r_fill_col    <= n_fill_col;
                r_fill_line   <= n_fill_line;
                r_held_color  <= n_held_color;
            end
        end
        if (advance && r_in_valid && n_out_valid) begin
            r_out_address    <= calc_address;
            r_out_data       <= calc_data;
            r_out_byte_count <= calc_byte_count;
            r_out_fill_done  <= n_out_fill_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_address;
    assign o_write_data    = r_out_data;
    assign o_byte_count    = r_out_byte_count;
    assign o_fill_done     = r_out_fill_done;

endmodule
